[design/oaht_pkg.sv]
// types and constants for the linear probing key/value store
`timescale 1ns / 1ps

package oaht_pkg;

   typedef logic [1:0] action_type;
   typedef logic [1:0] slot_status_type;

   localparam action_type ACT_GET    = 2'd0;
   localparam action_type ACT_SET    = 2'd1;
   localparam action_type ACT_DELETE = 2'd2;
   localparam action_type ACT_CLEAR  = 2'd3;

   localparam slot_status_type ST_EMPTY = 2'd0;
   localparam slot_status_type ST_LIVE  = 2'd1;
   localparam slot_status_type ST_TOMB  = 2'd2;

   localparam int KEY_W   = 32;
   localparam int HASH_W  = 32;
   localparam int VALUE_W = 64;
   localparam int LIMIT_W = 8;
   localparam int COUNT_W = 9;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 8'd192;

endpackage

[design/open_addressing_hash_table.sv]
// key/value store with linear probing and tombstones over on-chip memories
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; each one gives
// exactly one result, shown for one cycle with rsp_valid high, and the
// receiver cannot stall it. Slot status, key and value sit in three memories
// with one read port each, and a get, set or delete probe walks one slot per
// cycle. A get or delete on an empty store and a set over the load limit
// finish without probing. A clear sweeps the status memory one entry per
// cycle. After reset busy stays high while the status memory is swept to
// empty. The result appears the cycle after the transaction ends, and the
// next transaction can be taken in that same cycle.
module open_addressing_hash_table #(
   parameter int CAPACITY = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  oaht_pkg::action_type          req_action,
   input  logic [oaht_pkg::KEY_W-1:0]    req_key,
   input  logic [oaht_pkg::HASH_W-1:0]   req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0]  req_new_value,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_is_new,
   output logic                          rsp_full_res,
   output logic [oaht_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [oaht_pkg::COUNT_W-1:0]  rsp_used_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [oaht_pkg::LIMIT_W-1:0]  csr_load_limit
);
   import oaht_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_PROBE = 3'b010,
      S_CLEAR = 3'b100
   } state_type;

   // storage
   slot_status_type      stat_mem [CAPACITY];
   logic [KEY_W-1:0]     key_mem  [CAPACITY];
   logic [VALUE_W-1:0]   val_mem  [CAPACITY];

   slot_status_type      stat_rd_ff;
   logic [KEY_W-1:0]     key_rd_ff;
   logic [VALUE_W-1:0]   val_rd_ff;
   logic [IDX_W-1:0]     rd_addr;

   logic                 st_we;
   logic [IDX_W-1:0]     st_waddr;
   slot_status_type      st_wdata;
   logic                 key_we;
   logic                 val_we;
   logic [IDX_W-1:0]     kv_waddr;

   // control
   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     tomb_ff, tomb_in;
   logic                 have_tomb_ff, have_tomb_in;
   logic [IDX_W-1:0]     sweep_ff, sweep_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_is_new_ff, rsp_is_new_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic                 found;
   logic                 stop_empty;
   logic                 tomb_here;
   logic                 last_probe;
   logic                 have_tomb_now;
   logic [IDX_W-1:0]     tomb_now;
   logic [IDX_W-1:0]     slot;
   logic                 usable;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_is_new     = rsp_is_new_ff;
   assign rsp_full_res   = rsp_full_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_used_count = rsp_count_ff;

   // probe evaluation on the slot read in the previous cycle
   assign stop_empty    = (stat_rd_ff == ST_EMPTY);
   assign tomb_here     = (stat_rd_ff == ST_TOMB);
   assign found         = !stop_empty && !tomb_here && (key_rd_ff == key_ff);
   assign last_probe    = (n_ff == LAST_IDX);
   assign have_tomb_now = have_tomb_ff || tomb_here;
   assign tomb_now      = have_tomb_ff ? tomb_ff : cur_ff;
   assign usable        = found || stop_empty || have_tomb_now;

   always_comb begin
      if (found || (stop_empty && !have_tomb_ff)) begin
         slot = cur_ff;
      end else begin
         slot = tomb_now;
      end
   end

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      tomb_in       = tomb_ff;
      have_tomb_in  = have_tomb_ff;
      sweep_in      = sweep_ff;
      clr_rsp_in    = clr_rsp_ff;
      count_in      = count_ff;
      limit_in      = csr_valid ? csr_load_limit : limit_ff;

      rd_addr       = cur_ff + 1'b1;
      st_we         = 1'b0;
      st_waddr      = slot;
      st_wdata      = ST_LIVE;
      key_we        = 1'b0;
      val_we        = 1'b0;
      kv_waddr      = slot;

      rsp_valid_in  = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_is_new_in = 1'b0;
      rsp_full_in   = 1'b0;
      rsp_value_in  = '0;
      rsp_count_in  = count_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_key_hash[IDX_W-1:0];
            if (accept) begin
               act_in       = req_action;
               key_in       = req_key;
               val_in       = req_new_value;
               cur_in       = req_key_hash[IDX_W-1:0];
               n_in         = '0;
               have_tomb_in = 1'b0;
               case (req_action)
                  ACT_CLEAR: begin
                     state_in   = S_CLEAR;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                  end
                  ACT_SET: begin
                     if ((count_ff + 1'b1) > {1'b0, limit_ff}) begin
                        rsp_valid_in = 1'b1;
                        rsp_full_in  = 1'b1;
                     end else begin
                        state_in = S_PROBE;
                     end
                  end
                  default: begin
                     // get or delete on an empty store is a plain miss
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_PROBE;
                     end
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (!(found || stop_empty || last_probe)) begin
               cur_in  = cur_ff + 1'b1;
               n_in    = n_ff + 1'b1;
               tomb_in = tomb_now;
               have_tomb_in = have_tomb_now;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (act_ff)
                  ACT_GET: begin
                     rsp_hit_in   = found;
                     rsp_value_in = found ? val_rd_ff : '0;
                  end
                  ACT_SET: begin
                     if (found) begin
                        val_we   = 1'b1;
                     end else if (usable) begin
                        st_we         = 1'b1;
                        st_wdata      = ST_LIVE;
                        key_we        = 1'b1;
                        val_we        = 1'b1;
                        rsp_is_new_in = 1'b1;
                        // only a slot that was empty adds to the count
                        if (stop_empty && !have_tomb_ff) begin
                           count_in = count_ff + 1'b1;
                        end
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (found) begin
                        st_we      = 1'b1;
                        st_wdata   = ST_TOMB;
                        rsp_hit_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = sweep_ff;
            st_wdata = ST_EMPTY;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in     = S_IDLE;
               count_in     = '0;
               clr_rsp_in   = 1'b0;
               rsp_valid_in = clr_rsp_ff;
               rsp_count_in = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      tomb_ff       <= tomb_in;
      have_tomb_ff  <= have_tomb_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_is_new_ff <= rsp_is_new_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // status memory
   always_ff @(posedge clock) begin
      if (st_we) begin
         stat_mem[st_waddr] <= st_wdata;
      end
      stat_rd_ff <= stat_mem[rd_addr];
   end

   // key memory
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[kv_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[kv_waddr] <= val_ff;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

endmodule
